// ----- rtl/rlac_pkg.sv -----
// Shared types and constants of the radio link ack controller.
`default_nettype none
package rlac_pkg;

  localparam int unsigned ADDR_W = 4;

  localparam logic [15:0] TIMER_MAX     = 16'hffff;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  BCAST_RESET   = 8'hff;
  localparam logic [7:0]  HDR_BYTES     = 8'd3;

  typedef enum logic [2:0] {
    CMD_SEND    = 3'd0,
    CMD_LISTEN  = 3'd1,
    CMD_SENT    = 3'd2,
    CMD_PAYLOAD = 3'd3,
    CMD_TICK    = 3'd4,
    CMD_POLL    = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_WAIT       = 4'd0,
    ST_TX         = 4'd1,
    ST_SENT       = 4'd2,
    ST_RX         = 4'd3,
    ST_RECV       = 4'd4,
    ST_SEND_ACK   = 4'd5,
    ST_RECV_ACKED = 4'd6,
    ST_WAIT_ACK   = 4'd7,
    ST_ACK_OK     = 4'd8,
    ST_TX_TIMEOUT = 4'd9,
    ST_ACK_FAILED = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_RX      = 2'd1,
    MODE_TX      = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_NODE_ADDR  = 2'd0,
    REG_BCAST_ADDR = 2'd1,
    REG_PROMISC    = 2'd2,
    REG_TIMEOUT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] dest_addr;
    logic [7:0] payload_size;
    logic       want_ack;
    logic       is_ack_frame;
    logic       first_of_msg;
    logic       last_of_msg;
    logic [7:0] rx_len_byte;
    logic [7:0] rx_target;
    logic [7:0] rx_sender;
    logic       rx_wants_ack;
  } req_t;

  typedef struct packed {
    logic [3:0] link_status;
    logic [1:0] radio_mode;
    logic       tx_start;
    logic [7:0] tx_dest;
    logic [7:0] tx_len_byte;
    logic       tx_ack_bit;
    logic       tx_req_bit;
    logic       tx_first_bit;
    logic       tx_last_bit;
    logic       rx_accepted;
    logic [7:0] rx_payload_len;
  } rsp_t;

endpackage
`default_nettype wire

// ----- rtl/rlac_if.sv -----
// Valid/ready channels carrying event requests and link results.
`default_nettype none
interface rlac_req_if import rlac_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rlac_rsp_if import rlac_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/radio_link_ack_controller.sv -----
// A request passes an input register, then a result register, before its result is valid.
// Throughput: one request per cycle while results are taken; the link state updates as each result is registered.
// A stalled result holds the input register; a new request is taken once it drains.
// Reset (rst, synchronous, active high): status waiting, standby, timer 0, no pending
// ack request, config back to node 0, broadcast 255, not promiscuous, timeout 1000.
`default_nettype none
module radio_link_ack_controller import rlac_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  rlac_req_if.sink               req,
  rlac_rsp_if.source             rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  // configuration
  logic [7:0]  own_addr;
  logic [7:0]  bcast_addr;
  logic        promiscuous;
  logic [15:0] timeout_ms;

  // link state
  status_t     status_reg, status_next;
  mode_t       mode_reg, mode_next;
  logic [15:0] ms_timer, ms_timer_next;
  logic        pending_ack_req, pending_ack_req_next;

  // pipeline registers
  logic        in_valid;
  req_t        in_q;
  logic        out_valid;
  rsp_t        out_q, out_next;

  logic        advance;
  logic        process;
  logic        cfg_write;
  reg_idx_t    cfg_idx;

  logic [8:0]  tx_len_sum;
  logic        addr_ok;
  logic        timed_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);

  always_comb begin
    prdata = 32'd0;
    case (cfg_idx)
      REG_NODE_ADDR:  prdata = {24'd0, own_addr};
      REG_BCAST_ADDR: prdata = {24'd0, bcast_addr};
      REG_PROMISC:    prdata = {31'd0, promiscuous};
      REG_TIMEOUT:    prdata = {16'd0, timeout_ms};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr    <= 8'd0;
      bcast_addr  <= BCAST_RESET;
      promiscuous <= 1'b0;
      timeout_ms  <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_NODE_ADDR:  own_addr    <= pwdata[7:0];
        REG_BCAST_ADDR: bcast_addr  <= pwdata[7:0];
        REG_PROMISC:    promiscuous <= pwdata[0];
        REG_TIMEOUT:    timeout_ms  <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  assign advance   = !out_valid || rsp.ready;
  assign process   = in_valid && advance;
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  assign tx_len_sum = {1'b0, in_q.payload_size} + {1'b0, HDR_BYTES};
  assign addr_ok    = promiscuous || (in_q.rx_target == own_addr) ||
                      (in_q.rx_target == bcast_addr);
  assign timed_out  = ms_timer > timeout_ms;

  always_comb begin
    status_next          = status_reg;
    mode_next            = mode_reg;
    ms_timer_next        = ms_timer;
    pending_ack_req_next = pending_ack_req;
    out_next             = '0;

    case (in_q.cmd)
      CMD_SEND: begin
        out_next.tx_start     = 1'b1;
        out_next.tx_dest      = in_q.dest_addr;
        out_next.tx_len_byte  = tx_len_sum[8] ? 8'hff : tx_len_sum[7:0];
        out_next.tx_ack_bit   = in_q.is_ack_frame;
        out_next.tx_req_bit   = in_q.want_ack && !in_q.is_ack_frame;
        out_next.tx_first_bit = in_q.first_of_msg;
        out_next.tx_last_bit  = in_q.last_of_msg;
        pending_ack_req_next  = in_q.want_ack;
        mode_next             = MODE_TX;
        ms_timer_next         = 16'd0;
        status_next           = ST_TX;
      end
      CMD_LISTEN: begin
        mode_next   = MODE_RX;
        status_next = ST_RX;
      end
      CMD_SENT: begin
        if (status_reg == ST_TX || status_reg == ST_SEND_ACK) begin
          if (pending_ack_req) begin
            mode_next     = MODE_RX;
            ms_timer_next = 16'd0;
            status_next   = ST_WAIT_ACK;
          end else begin
            mode_next   = MODE_STANDBY;
            status_next = (status_reg == ST_TX) ? ST_SENT : ST_RECV_ACKED;
          end
        end
      end
      CMD_PAYLOAD: begin
        if (status_reg == ST_RX || status_reg == ST_WAIT_ACK) begin
          if (!addr_ok) begin
            mode_next = MODE_RX;
          end else begin
            out_next.rx_accepted    = 1'b1;
            out_next.rx_payload_len = (in_q.rx_len_byte >= HDR_BYTES) ?
                                      in_q.rx_len_byte - HDR_BYTES : 8'd0;
            pending_ack_req_next    = in_q.rx_wants_ack;
            mode_next               = MODE_STANDBY;
            if (status_reg == ST_WAIT_ACK) begin
              status_next = ST_ACK_OK;
            end else if (in_q.rx_wants_ack && in_q.rx_target != bcast_addr) begin
              // answer with an empty ack frame back to the sender
              out_next.tx_start     = 1'b1;
              out_next.tx_dest      = in_q.rx_sender;
              out_next.tx_len_byte  = HDR_BYTES;
              out_next.tx_ack_bit   = 1'b1;
              out_next.tx_first_bit = 1'b1;
              out_next.tx_last_bit  = 1'b1;
              pending_ack_req_next  = 1'b0;
              mode_next             = MODE_TX;
              ms_timer_next         = 16'd0;
              status_next           = ST_SEND_ACK;
            end else begin
              status_next = ST_RECV;
            end
          end
        end
      end
      CMD_TICK: begin
        if (ms_timer != TIMER_MAX) ms_timer_next = ms_timer + 16'd1;
      end
      CMD_POLL: begin
        if ((status_reg == ST_TX || status_reg == ST_SEND_ACK) && timed_out) begin
          mode_next   = MODE_STANDBY;
          status_next = ST_TX_TIMEOUT;
        end else if (status_reg == ST_WAIT_ACK && timed_out) begin
          status_next = ST_ACK_FAILED;
        end
      end
      default: ;
    endcase

    out_next.link_status = status_next;
    out_next.radio_mode  = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      status_reg      <= ST_WAIT;
      mode_reg        <= MODE_STANDBY;
      ms_timer        <= 16'd0;
      pending_ack_req <= 1'b0;
    end else begin
      if (req.ready) in_valid <= req.valid;
      if (advance) out_valid <= in_valid;
      if (process) begin
        status_reg      <= status_next;
        mode_reg        <= mode_next;
        ms_timer        <= ms_timer_next;
        pending_ack_req <= pending_ack_req_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) in_q <= req.data;
    if (process) out_q <= out_next;
  end

`ifndef SYNTH
  a_tx_start_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.tx_start |-> out_q.radio_mode == MODE_TX &&
      (out_q.link_status == ST_TX || out_q.link_status == ST_SEND_ACK))
    else $error("tx_start without transmit mode");

  a_ack_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_q.tx_start && out_q.link_status == ST_SEND_ACK |->
      out_q.tx_len_byte == HDR_BYTES && out_q.tx_ack_bit && !out_q.tx_req_bit)
    else $error("ack frame header malformed");

  a_rx_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_q.rx_accepted |-> out_q.rx_payload_len == 8'd0)
    else $error("payload length without accepted frame");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(status_reg) && $stable(mode_reg) && $stable(ms_timer))
    else $error("link state changed while result stalled");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (rst)
    process |=> out_q.link_status == status_reg && out_q.radio_mode == mode_reg)
    else $error("result disagrees with link state");
`endif

endmodule
`default_nettype wire

// ----- test/rlac_checker.sv -----
// Link result checker: tracks config writes, predicts each result, compares it with the block.
module rlac_checker import rlac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rlac_req_if               req,
  rlac_rsp_if               rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                mismatch_cnt,
  output int                waiting_cnt
);

  logic [7:0]  own_addr;
  logic [7:0]  bcast_addr;
  logic        promisc;
  logic [15:0] timeout_lim;

  status_t     link_st;
  mode_t       radio_md;
  logic [15:0] ms_cnt;
  logic        ack_pend;

  rsp_t        link_q[$];
  int          errs;

  function automatic logic timer_expired();
    return ms_cnt > timeout_lim;
  endfunction

  // Advances the link state by one request and returns the result it should produce.
  function automatic rsp_t link_step(input req_t ev);
    rsp_t       r;
    logic       hit;
    logic [8:0] len9;
    r = '0;
    case (ev.cmd)
      CMD_SEND: begin
        len9 = {1'b0, ev.payload_size} + {1'b0, HDR_BYTES};
        r.tx_start     = 1'b1;
        r.tx_dest      = ev.dest_addr;
        r.tx_len_byte  = len9[8] ? 8'hff : len9[7:0];
        r.tx_ack_bit   = ev.is_ack_frame;
        r.tx_req_bit   = ev.want_ack & ~ev.is_ack_frame;
        r.tx_first_bit = ev.first_of_msg;
        r.tx_last_bit  = ev.last_of_msg;
        ack_pend = ev.want_ack;
        radio_md = MODE_TX;
        ms_cnt   = '0;
        link_st  = ST_TX;
      end
      CMD_LISTEN: begin
        radio_md = MODE_RX;
        link_st  = ST_RX;
      end
      CMD_SENT: begin
        if (link_st == ST_TX || link_st == ST_SEND_ACK) begin
          if (ack_pend) begin
            radio_md = MODE_RX;
            ms_cnt   = '0;
            link_st  = ST_WAIT_ACK;
          end else begin
            radio_md = MODE_STANDBY;
            link_st  = (link_st == ST_TX) ? ST_SENT : ST_RECV_ACKED;
          end
        end
      end
      CMD_PAYLOAD: begin
        if (link_st == ST_RX || link_st == ST_WAIT_ACK) begin
          hit = promisc || ev.rx_target == own_addr || ev.rx_target == bcast_addr;
          if (!hit) begin
            radio_md = MODE_RX;
          end else begin
            r.rx_accepted    = 1'b1;
            r.rx_payload_len = (ev.rx_len_byte >= HDR_BYTES) ? ev.rx_len_byte - HDR_BYTES : '0;
            ack_pend = ev.rx_wants_ack;
            radio_md = MODE_STANDBY;
            if (link_st == ST_WAIT_ACK) begin
              link_st = ST_ACK_OK;
            end else if (ev.rx_wants_ack && ev.rx_target != bcast_addr) begin
              // answer with an empty ack frame
              r.tx_start     = 1'b1;
              r.tx_dest      = ev.rx_sender;
              r.tx_len_byte  = HDR_BYTES;
              r.tx_ack_bit   = 1'b1;
              r.tx_first_bit = 1'b1;
              r.tx_last_bit  = 1'b1;
              ack_pend = 1'b0;
              radio_md = MODE_TX;
              ms_cnt   = '0;
              link_st  = ST_SEND_ACK;
            end else begin
              link_st = ST_RECV;
            end
          end
        end
      end
      CMD_TICK: begin
        if (ms_cnt != TIMER_MAX) ms_cnt = ms_cnt + 16'd1;
      end
      CMD_POLL: begin
        if ((link_st == ST_TX || link_st == ST_SEND_ACK) && timer_expired()) begin
          radio_md = MODE_STANDBY;
          link_st  = ST_TX_TIMEOUT;
        end else if (link_st == ST_WAIT_ACK && timer_expired()) begin
          link_st = ST_ACK_FAILED;
        end
      end
      default: ;
    endcase
    r.link_status = link_st;
    r.radio_mode  = radio_md;
    return r;
  endfunction

  function automatic void check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t exp_r;
    rsp_t act_r;
    if (rst) begin
      own_addr    = '0;
      bcast_addr  = BCAST_RESET;
      promisc     = 1'b0;
      timeout_lim = TIMEOUT_RESET;
      link_st     = ST_WAIT;
      radio_md    = MODE_STANDBY;
      ms_cnt      = '0;
      ack_pend    = 1'b0;
      link_q.delete();
      errs        = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_NODE_ADDR:  own_addr    = pwdata[7:0];
          REG_BCAST_ADDR: bcast_addr  = pwdata[7:0];
          REG_PROMISC:    promisc     = pwdata[0];
          REG_TIMEOUT:    timeout_lim = pwdata[15:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        act_r = rsp.data;
        if (link_q.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d", $time,
                   act_r.link_status);
          errs++;
        end else begin
          exp_r = link_q.pop_front();
          check_field("link_status", exp_r.link_status, act_r.link_status);
          check_field("radio_mode", exp_r.radio_mode, act_r.radio_mode);
          check_field("tx_start", exp_r.tx_start, act_r.tx_start);
          check_field("tx_dest", exp_r.tx_dest, act_r.tx_dest);
          check_field("tx_len_byte", exp_r.tx_len_byte, act_r.tx_len_byte);
          check_field("tx_ack_bit", exp_r.tx_ack_bit, act_r.tx_ack_bit);
          check_field("tx_req_bit", exp_r.tx_req_bit, act_r.tx_req_bit);
          check_field("tx_first_bit", exp_r.tx_first_bit, act_r.tx_first_bit);
          check_field("tx_last_bit", exp_r.tx_last_bit, act_r.tx_last_bit);
          check_field("rx_accepted", exp_r.rx_accepted, act_r.rx_accepted);
          check_field("rx_payload_len", exp_r.rx_payload_len, act_r.rx_payload_len);
        end
      end
      if (req.valid && req.ready) link_q.push_back(link_step(req.data));
    end
    mismatch_cnt <= errs;
    waiting_cnt  <= link_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top: event stimulus, register writes, stall watchdog and final verdict.
module tb_top;
  import rlac_pkg::*;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          PHASES       = 6;
  localparam logic [2:0]  CMD_BAD_LO   = 3'd6;
  localparam logic [2:0]  CMD_BAD_HI   = 3'd7;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int          mismatch_cnt;
  int          waiting_cnt;
  int          idle_cycles;
  int          items_sent;
  logic        no_gaps;
  logic [7:0]  cur_node;
  logic [7:0]  cur_bcast;
  logic [15:0] cur_timeout;

  rlac_req_if req_ch();
  rlac_rsp_if rsp_ch();

  radio_link_ack_controller dut (
    .clk, .rst, .req(req_ch), .rsp(rsp_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  rlac_checker chk (
    .clk, .rst, .req(req_ch), .rsp(rsp_ch),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatch_cnt, .waiting_cnt
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 36);
  end

  // nothing accepted for too long means the block hung
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[radio_link_ack_controller] ERROR");
      $finish;
    end
  end

  function automatic req_t make_event(input logic [2:0] code);
    req_t        ev;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    ev = bits[$bits(req_t)-1:0];
    ev.cmd = code;
    return ev;
  endfunction

  // All tasks start and end right after a falling edge.
  task automatic push_event(input req_t ev);
    while (!no_gaps && $urandom_range(99) < 36) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= ev;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic tick_run(input int n);
    repeat (n) push_event(make_event(CMD_TICK));
  endtask

  task automatic rx_frame(input logic [7:0] tgt);
    req_t ev;
    ev = make_event(CMD_PAYLOAD);
    ev.rx_target = tgt;
    if ($urandom_range(7) == 0) ev.rx_len_byte = 8'($urandom_range(0, 3));
    push_event(ev);
  endtask

  function automatic logic [7:0] pick_target();
    case ($urandom_range(3))
      0, 1:    return cur_node;
      2:       return cur_bcast;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int pick_ticks();
    if (cur_timeout <= 16'd8) return $urandom_range(0, cur_timeout + 2);
    return $urandom_range(0, 3);
  endfunction

  // stop requests and let every outstanding result come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (waiting_cnt != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_link(input logic [7:0] node, input logic [7:0] bcast, input logic prom,
                          input logic [15:0] tmo);
    drain();
    apb_write(REG_NODE_ADDR, {24'd0, node});
    apb_write(REG_BCAST_ADDR, {24'd0, bcast});
    apb_write(REG_PROMISC, {31'd0, prom});
    apb_write(REG_TIMEOUT, {16'd0, tmo});
    cur_node    = node;
    cur_bcast   = bcast;
    cur_timeout = tmo;
  endtask

  task automatic directed_events();
    req_t ev;
    // events that the idle link ignores
    push_event(make_event(CMD_POLL));
    push_event(make_event(CMD_SENT));
    ev = make_event(CMD_PAYLOAD);
    ev.rx_target = cur_node;
    push_event(ev);
    push_event(make_event(CMD_BAD_LO));
    push_event(make_event(CMD_BAD_HI));
    // ack frame asking for ack: request bit must stay clear
    ev = make_event(CMD_SEND);
    ev.dest_addr = 8'hff; ev.payload_size = 8'd252; ev.want_ack = 1'b1;
    ev.is_ack_frame = 1'b1; ev.first_of_msg = 1'b1; ev.last_of_msg = 1'b0;
    push_event(ev);
    // oversized payload saturates the length byte
    ev = make_event(CMD_SEND);
    ev.dest_addr = 8'h00; ev.payload_size = 8'hff; ev.want_ack = 1'b0;
    ev.is_ack_frame = 1'b0; ev.first_of_msg = 1'b0; ev.last_of_msg = 1'b1;
    push_event(ev);
    push_event(make_event(CMD_SENT));
    ev = make_event(CMD_SEND);
    ev.payload_size = 8'd0; ev.want_ack = 1'b1; ev.is_ack_frame = 1'b0;
    push_event(ev);
    push_event(make_event(CMD_SENT));
    ev = make_event(CMD_PAYLOAD);
    ev.rx_target = 8'h12;
    push_event(ev);
    // ack arrives with a short header
    ev = make_event(CMD_PAYLOAD);
    ev.rx_target = cur_node; ev.rx_len_byte = 8'd2; ev.rx_wants_ack = 1'b1;
    push_event(ev);
    push_event(make_event(CMD_LISTEN));
    ev = make_event(CMD_PAYLOAD);
    ev.rx_target = cur_node; ev.rx_len_byte = 8'hff; ev.rx_sender = 8'hab;
    ev.rx_wants_ack = 1'b1;
    push_event(ev);
    push_event(make_event(CMD_SENT));
    push_event(make_event(CMD_LISTEN));
    // broadcast never gets an ack
    ev = make_event(CMD_PAYLOAD);
    ev.rx_target = cur_bcast; ev.rx_wants_ack = 1'b1;
    push_event(ev);
    push_event(make_event(CMD_LISTEN));
    ev = make_event(CMD_PAYLOAD);
    ev.rx_target = cur_node; ev.rx_len_byte = 8'd3; ev.rx_wants_ack = 1'b0;
    push_event(ev);
    ev = make_event(CMD_SEND);
    ev.want_ack = 1'b1; ev.is_ack_frame = 1'b0;
    push_event(ev);
    push_event(make_event(CMD_POLL));
    push_event(make_event(CMD_TICK));
    push_event(make_event(CMD_SENT));
    push_event(make_event(CMD_POLL));
  endtask

  task automatic random_sequence();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // transmit, maybe wait for the ack
      push_event(make_event(CMD_SEND));
      if ($urandom_range(3) == 0) begin
        tick_run(pick_ticks());
        push_event(make_event(CMD_POLL));
      end
      if ($urandom_range(5) != 0) push_event(make_event(CMD_SENT));
      tick_run(pick_ticks());
      if ($urandom_range(2) != 0) rx_frame(pick_target());
      push_event(make_event(CMD_POLL));
    end else if (pick < 75) begin
      // listen, filter, maybe answer with an ack
      push_event(make_event(CMD_LISTEN));
      if ($urandom_range(3) == 0) rx_frame(8'($urandom));
      rx_frame(pick_target());
      if ($urandom_range(1) == 0) begin
        tick_run(pick_ticks());
        push_event(make_event(CMD_POLL));
      end
      push_event(make_event(CMD_SENT));
    end else begin
      repeat ($urandom_range(1, 3)) push_event(make_event(3'($urandom_range(0, 7))));
    end
  endtask

  task automatic random_phase(input int goal);
    while (items_sent < goal) begin
      if ($urandom_range(39) == 0) drain();
      random_sequence();
    end
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    no_gaps      = 1'b0;
    idle_cycles  = 0;
    items_sent   = 0;
    cur_node     = '0;
    cur_bcast    = BCAST_RESET;
    cur_timeout  = TIMEOUT_RESET;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_events();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_link(8'h00, 8'hff, 1'b0, 16'd0);
        1: set_link(8'hff, 8'h00, 1'b1, 16'd3);
        2: set_link(8'($urandom), 8'($urandom), 1'b0, 16'($urandom_range(1, 8)));
        3: set_link(8'h5a, 8'h5a, 1'b0, 16'd2);
        4: set_link(8'($urandom), 8'($urandom), 1'($urandom), 16'hffff);
        default: set_link(8'($urandom), 8'($urandom), 1'b1, 16'($urandom_range(4, 8)));
      endcase
      no_gaps <= (ph == 1);
      random_phase(items_sent + RANDOM_ITEMS / PHASES);
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatch_cnt == 0 && waiting_cnt == 0)
      $display("[radio_link_ack_controller] OK");
    else
      $display("[radio_link_ack_controller] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rlac_pkg.sv
rtl/rlac_if.sv
rtl/radio_link_ack_controller.sv
test/rlac_checker.sv
test/tb_top.sv
